// ===== hdl/pbi_pkg.sv =====
// ----------------------------------------------------------------------------
// pbi_pkg
// Shared widths, reset values and the token that walks the palette cell chain.
// ----------------------------------------------------------------------------
package pbi_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int COLOR_W         = 32;
  localparam int IDX_W           = 8;
  localparam int CNT_W           = 9;
  localparam int CFG_W           = 4;

  localparam logic [CFG_W-1:0] IDX_BITS_RESET = 4'd8;
  localparam logic [CFG_W-1:0] IDX_BITS_MIN   = 4'd1;
  localparam logic [CFG_W-1:0] IDX_BITS_MAX   = 4'd8;

  // one pixel in flight, plus what the cells it passed have found out
  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
    logic               first;
    logic               found;   // matched or appended somewhere upstream
    logic               is_new;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   count;   // entries held in cells passed so far
  } token_t;

endpackage

// ===== hdl/pbi_cell.sv =====
// ----------------------------------------------------------------------------
// pbi_cell
// One palette slot: holds a color, compares the passing pixel, claims it when
// empty, and hands the updated token to the next slot.
// ----------------------------------------------------------------------------
module pbi_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [pbi_pkg::CNT_W-1:0] cap,
  input  pbi_pkg::token_t          tok_in,
  output pbi_pkg::token_t          tok_out
);

  localparam logic [pbi_pkg::IDX_W-1:0] MY_IDX  = pbi_pkg::IDX_W'(CELL_IDX);
  localparam logic [pbi_pkg::CNT_W-1:0] MY_POS  = pbi_pkg::CNT_W'(CELL_IDX);
  localparam logic [pbi_pkg::CNT_W-1:0] MY_CNT  = pbi_pkg::CNT_W'(CELL_IDX + 1);

  logic                          entry_valid;
  logic [pbi_pkg::COLOR_W-1:0]   entry_color;
  pbi_pkg::token_t               tok;
  pbi_pkg::token_t               tok_next;
  logic                          held;
  logic                          hit;
  logic                          take;

  // a new image empties the slot before the compare
  assign held = entry_valid & ~tok_in.first;
  assign hit  = tok_in.valid & held & ~tok_in.found & (tok_in.color == entry_color);
  assign take = tok_in.valid & ~held & ~tok_in.found & (MY_POS < cap);

  always_comb begin
    tok_next        = tok_in;
    tok_next.found  = tok_in.found | hit | take;
    tok_next.is_new = tok_in.is_new | take;
    if (hit || take) begin
      tok_next.idx = MY_IDX;
    end
    if (held || take) begin
      tok_next.count = MY_CNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      tok         <= '0;
    end else if (adv) begin
      tok <= tok_next;
      if (tok_in.valid) begin
        entry_valid <= held | take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      entry_color <= tok_in.color;
    end
  end

  assign tok_out = tok;

endmodule

// ===== hdl/palette_builder_indexer.sv =====
// ----------------------------------------------------------------------------
// palette_builder_indexer
// Builds a color palette on first sight and maps each pixel to its index.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ---------------------------------
//  in       sink       in_valid / in_stall   pixel_color, first_pixel
//  out      source     out_valid / out_stall palette_index, is_new, overflow,
//                                            entries_used
//  cfg      sink       cfg_valid / cfg_ready cfg_data (index_bits)
//
//  One pixel is taken per cycle while the chain is not stalled; each result
//  is registered in every cell of the chain in turn, one slot after another.
//  Reset empties every slot and loads index_bits = 8; no clearing pass.
//  A stalled result freezes the whole chain, and in_stall follows it.
//  cfg_ready is always high; writes are only expected while the chain is idle.
//
// ----------------------------------------------------------------------------
module palette_builder_indexer #(
  parameter int MAX_ENTRIES = pbi_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pbi_pkg::COLOR_W-1:0] pixel_color,
  input  logic                        first_pixel,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pbi_pkg::IDX_W-1:0]   palette_index,
  output logic                        is_new,
  output logic                        overflow,
  output logic [pbi_pkg::CNT_W-1:0]   entries_used,
  // index_bits register
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pbi_pkg::CFG_W-1:0]   cfg_data
);

  localparam logic [pbi_pkg::CNT_W-1:0] CAP_LIMIT = pbi_pkg::CNT_W'(MAX_ENTRIES);

  logic [pbi_pkg::CFG_W-1:0] index_bits;
  logic [pbi_pkg::CFG_W-1:0] bits_eff;
  logic [pbi_pkg::CNT_W-1:0] cap_pow;
  logic [pbi_pkg::CNT_W-1:0] cap;
  logic                      adv;
  pbi_pkg::token_t           chain [0:MAX_ENTRIES];

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= pbi_pkg::IDX_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      index_bits <= cfg_data;
    end
  end

  // capacity: 2^index_bits, index_bits clamped to 1..8, then to MAX_ENTRIES
  always_comb begin
    bits_eff = index_bits;
    if (index_bits < pbi_pkg::IDX_BITS_MIN) begin
      bits_eff = pbi_pkg::IDX_BITS_MIN;
    end else if (index_bits > pbi_pkg::IDX_BITS_MAX) begin
      bits_eff = pbi_pkg::IDX_BITS_MAX;
    end
    cap_pow = pbi_pkg::CNT_W'(1) << bits_eff;
    cap     = (cap_pow > CAP_LIMIT) ? CAP_LIMIT : cap_pow;
  end

  // whole chain moves together unless the result at its end is held
  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = in_valid;
    chain[0].color  = pixel_color;
    chain[0].first  = first_pixel;
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    pbi_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .cap     (cap),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  // last cell's token register doubles as the output register
  assign out_valid     = chain[MAX_ENTRIES].valid;
  assign palette_index = chain[MAX_ENTRIES].idx;
  assign is_new        = chain[MAX_ENTRIES].is_new;
  assign overflow      = ~chain[MAX_ENTRIES].found;
  assign entries_used  = chain[MAX_ENTRIES].count;

`ifndef ASSERT_OFF
  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> !is_new && palette_index == '0)
    else $error("overflow result carries an index or new flag");

  a_new_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new |-> entries_used == pbi_pkg::CNT_W'(palette_index) + 1'b1)
    else $error("appended entry is not the last one held");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !overflow |-> pbi_pkg::CNT_W'(palette_index) < entries_used)
    else $error("index beyond entries held");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entries_used <= CAP_LIMIT)
    else $error("entry count beyond chain length");
`endif

endmodule
